>>> sv/ffba_pkg.sv
package ffba_pkg;

  localparam int ARENA_BYTES   = 1048576;
  localparam int TABLE_ENTRIES = 1024;

  localparam int KIND_W = 2;
  localparam int ADDR_W = 20;
  localparam int LEN_W  = 21;
  localparam int NEED_W = 22;
  localparam int CUR_W  = 23;
  localparam int STAT_W = 2;
  localparam int LIVE_W = 11;
  localparam int SKIP_W = 5;

  localparam logic [SKIP_W-1:0] SKIP_RESET = 5'd4;

  typedef enum logic [KIND_W-1:0] {
    K_ALLOC   = 2'd0,
    K_FREE    = 2'd1,
    K_REALLOC = 2'd2,
    K_COUNT   = 2'd3
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_ARENA   = 2'd2,
    ST_TABLE   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_APPLY,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    AM_WRITE,
    AM_INSERT,
    AM_KILL
  } apply_mode_t;

  typedef struct packed {
    logic              live;
    logic [LEN_W-1:0]  req;
    logic [LEN_W-1:0]  rlen;
    logic [ADDR_W-1:0] base;
  } entry_t;

  // ring control from the sequencer to the chain
  typedef struct packed {
    logic   shift;
    entry_t wb;
  } ring_ctl_t;

endpackage

>>> sv/ffba_in_if.sv
interface ffba_in_if;
  logic                         valid;
  logic                         ready;
  logic [ffba_pkg::KIND_W-1:0]  kind;
  logic [ffba_pkg::LEN_W-1:0]   size;
  logic [ffba_pkg::ADDR_W-1:0]  address;
  logic                         address_null;

  modport source (output valid, output kind, output size, output address,
                  output address_null, input ready);
  modport sink (input valid, input kind, input size, input address,
                input address_null, output ready);
endinterface

>>> sv/ffba_out_if.sv
interface ffba_out_if;
  logic                         valid;
  logic                         ready;
  logic [ffba_pkg::ADDR_W-1:0]  block_address;
  logic [ffba_pkg::STAT_W-1:0]  status;
  logic                         copy_needed;
  logic [ffba_pkg::ADDR_W-1:0]  copy_source;
  logic [ffba_pkg::LEN_W-1:0]   copy_length;
  logic [ffba_pkg::LIVE_W-1:0]  live_count;

  modport source (output valid, output block_address, output status,
                  output copy_needed, output copy_source, output copy_length,
                  output live_count, input ready);
  modport sink (input valid, input block_address, input status,
                input copy_needed, input copy_source, input copy_length,
                input live_count, output ready);
endinterface

>>> sv/ffba_cell.sv
module ffba_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             shift,
  input  ffba_pkg::entry_t d,
  output ffba_pkg::entry_t q
);

  logic                          live_r;
  logic [ffba_pkg::LEN_W-1:0]    req_r;
  logic [ffba_pkg::LEN_W-1:0]    rlen_r;
  logic [ffba_pkg::ADDR_W-1:0]   base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= 1'b0;
    end else if (shift) begin
      live_r <= d.live;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      req_r  <= d.req;
      rlen_r <= d.rlen;
      base_r <= d.base;
    end
  end

  assign q.live = live_r;
  assign q.req  = req_r;
  assign q.rlen = rlen_r;
  assign q.base = base_r;

endmodule

>>> sv/ffba_ctrl.sv
module ffba_ctrl #(
  parameter int TABLE_ENTRIES = ffba_pkg::TABLE_ENTRIES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  ffba_in_if.sink                       in_ch,
  ffba_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [ffba_pkg::SKIP_W-1:0]   cfg_wdata,
  input  ffba_pkg::entry_t              head,
  output ffba_pkg::ring_ctl_t           ring
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);
  localparam logic [ffba_pkg::CUR_W-1:0] ARENA_CUR = ffba_pkg::CUR_W'(ffba_pkg::ARENA_BYTES);

  ffba_pkg::state_t state_r, state_nxt;

  logic [IDX_W-1:0]              step_r;
  logic [CNT_W-1:0]              count_r;
  logic [ffba_pkg::SKIP_W-1:0]   skip_r;

  ffba_pkg::kind_t               kind_r;
  logic                          null_r;
  logic [ffba_pkg::LEN_W-1:0]    size_r;
  logic [ffba_pkg::ADDR_W-1:0]   addr_r;
  logic [ffba_pkg::NEED_W-1:0]   need_r;
  logic                          free_phase_r;
  logic                          move_r;

  // scan statistics
  logic [ffba_pkg::CUR_W-1:0]    cursor_r;
  logic                          gfound_r;
  logic [IDX_W-1:0]              gidx_r;
  logic                          reuse_r;
  logic                          prevlive_r;
  logic                          ffound_r;
  logic [IDX_W-1:0]              fidx_r;
  logic [ffba_pkg::LEN_W-1:0]    frlen_r;
  logic [ffba_pkg::LEN_W-1:0]    freq_r;
  logic [CNT_W-1:0]              lastlive_r;
  logic [CNT_W-1:0]              livecnt_r;

  ffba_pkg::apply_mode_t         am_r;
  logic [IDX_W-1:0]              apos_r;
  ffba_pkg::entry_t              aval_r;
  ffba_pkg::entry_t              hold_r;

  // per-operation result and the output register
  ffba_pkg::status_t             res_st_r;
  logic [ffba_pkg::ADDR_W-1:0]   res_addr_r;
  logic                          res_copy_r;
  logic [ffba_pkg::ADDR_W-1:0]   res_csrc_r;
  logic [ffba_pkg::LEN_W-1:0]    res_clen_r;
  logic [CNT_W-1:0]              res_live_r;

  logic                          out_valid_r;
  ffba_pkg::status_t             out_st_r;
  logic [ffba_pkg::ADDR_W-1:0]   out_addr_r;
  logic                          out_copy_r;
  logic [ffba_pkg::ADDR_W-1:0]   out_csrc_r;
  logic [ffba_pkg::LEN_W-1:0]    out_clen_r;
  logic [ffba_pkg::LIVE_W-1:0]   out_live_r;

  logic in_acc, last_step, out_free, stat_clr, free_mode;
  logic [ffba_pkg::NEED_W-1:0] need_raw;

  // scan signals
  logic                        in_tab, bounds, fits, g_hit, g_adv, f_hit, ll_upd, lc_upd;
  logic [ffba_pkg::CUR_W-1:0]  hb, hend;

  // alloc decision
  logic                        a_ok, a_inc;
  ffba_pkg::status_t           a_st;
  ffba_pkg::apply_mode_t       a_mode;
  logic [IDX_W-1:0]            a_pos;
  ffba_pkg::entry_t            a_val;

  // overall decision
  logic                        dec_apply, dec_inc, dec_trim, dec_move;
  ffba_pkg::status_t           dec_st;
  ffba_pkg::apply_mode_t       dec_mode;
  logic [IDX_W-1:0]            dec_pos;
  ffba_pkg::entry_t            dec_val;
  logic [ffba_pkg::ADDR_W-1:0] dec_addr;

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign last_step = (step_r == LAST_IDX);
  assign out_free  = !out_valid_r || out_ch.ready;
  assign stat_clr  = (state_r == ffba_pkg::S_APPLY) && last_step && move_r && !free_phase_r;
  assign free_mode = free_phase_r || (kind_r == ffba_pkg::K_FREE);
  assign need_raw  = {1'b0, in_ch.size} + ffba_pkg::NEED_W'(3);

  // scan of the entry at the head of the ring
  always_comb begin
    in_tab = CNT_W'(step_r) < count_r;
    hb     = ffba_pkg::CUR_W'(head.base);
    hend   = hb + ffba_pkg::CUR_W'(head.rlen);
    bounds = in_tab && !gfound_r && head.live && (head.rlen != '0);
    fits   = (hb < cursor_r) || ((hb - cursor_r) >= ffba_pkg::CUR_W'(need_r));
    g_hit  = bounds && fits;
    g_adv  = bounds && !fits;
    f_hit  = in_tab && !ffound_r && head.live && (head.base == addr_r);
    ll_upd = in_tab && head.live && !(f_hit && free_mode);
    lc_upd = in_tab && head.live && (32'(step_r) >= 32'(skip_r));
  end

  // first-fit outcome
  always_comb begin
    a_ok   = 1'b0;
    a_inc  = 1'b0;
    a_st   = ffba_pkg::ST_OK;
    a_mode = ffba_pkg::AM_INSERT;
    a_pos  = gidx_r;
    a_val.live = 1'b1;
    a_val.req  = size_r;
    a_val.rlen = need_r[ffba_pkg::LEN_W-1:0];
    a_val.base = cursor_r[ffba_pkg::ADDR_W-1:0];
    priority if (gfound_r && reuse_r) begin
      a_ok   = 1'b1;
      a_mode = ffba_pkg::AM_WRITE;
      a_pos  = gidx_r - IDX_W'(1);
    end else if (gfound_r) begin
      if (count_r == FULL_CNT) begin
        a_st = ffba_pkg::ST_TABLE;
      end else begin
        a_ok  = 1'b1;
        a_inc = 1'b1;
      end
    end else if ((cursor_r >= ARENA_CUR) ||
                 ((cursor_r + ffba_pkg::CUR_W'(need_r)) > ARENA_CUR)) begin
      a_st = ffba_pkg::ST_ARENA;
    end else if (count_r == FULL_CNT) begin
      a_st = ffba_pkg::ST_TABLE;
    end else begin
      a_ok  = 1'b1;
      a_inc = 1'b1;
      a_pos = IDX_W'(count_r);
    end
  end

  always_comb begin
    dec_apply = 1'b0;
    dec_inc   = 1'b0;
    dec_trim  = 1'b0;
    dec_move  = 1'b0;
    dec_st    = ffba_pkg::ST_OK;
    dec_mode  = ffba_pkg::AM_WRITE;
    dec_pos   = fidx_r;
    dec_val   = a_val;
    dec_addr  = '0;
    priority if (free_mode) begin
      dec_trim = 1'b1;
      if (ffound_r) begin
        dec_apply = 1'b1;
        dec_mode  = ffba_pkg::AM_KILL;
      end else begin
        dec_st = ffba_pkg::ST_UNKNOWN;
      end
    end else if (kind_r == ffba_pkg::K_COUNT) begin
      dec_trim = 1'b1;
    end else if ((kind_r == ffba_pkg::K_REALLOC) && !null_r && !ffound_r) begin
      dec_st = ffba_pkg::ST_UNKNOWN;
    end else if ((kind_r == ffba_pkg::K_REALLOC) && !null_r &&
                 ({1'b0, frlen_r} >= need_r)) begin
      // shrink in place
      dec_apply    = 1'b1;
      dec_val.base = addr_r;
      dec_addr     = addr_r;
    end else begin
      dec_apply = a_ok;
      dec_inc   = a_inc;
      dec_st    = a_st;
      dec_mode  = a_mode;
      dec_pos   = a_pos;
      dec_addr  = a_ok ? cursor_r[ffba_pkg::ADDR_W-1:0] : '0;
      dec_move  = a_ok && (kind_r == ffba_pkg::K_REALLOC) && !null_r;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ffba_pkg::S_IDLE: begin
        if (in_acc) begin
          state_nxt = ((ffba_pkg::kind_t'(in_ch.kind) == ffba_pkg::K_FREE) &&
                       in_ch.address_null) ? ffba_pkg::S_DONE : ffba_pkg::S_SCAN;
        end
      end
      ffba_pkg::S_SCAN: begin
        if (last_step) state_nxt = ffba_pkg::S_DECIDE;
      end
      ffba_pkg::S_DECIDE: begin
        state_nxt = dec_apply ? ffba_pkg::S_APPLY : ffba_pkg::S_DONE;
      end
      ffba_pkg::S_APPLY: begin
        if (last_step) begin
          state_nxt = (move_r && !free_phase_r) ? ffba_pkg::S_SCAN : ffba_pkg::S_DONE;
        end
      end
      ffba_pkg::S_DONE: begin
        if (out_free) state_nxt = ffba_pkg::S_IDLE;
      end
      default: state_nxt = ffba_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ch.ready = (state_r == ffba_pkg::S_IDLE);
    ring.shift  = (state_r == ffba_pkg::S_SCAN) || (state_r == ffba_pkg::S_APPLY);
    ring.wb     = head;
    if (state_r == ffba_pkg::S_APPLY) begin
      unique case (am_r)
        ffba_pkg::AM_WRITE: begin
          if (step_r == apos_r) ring.wb = aval_r;
        end
        ffba_pkg::AM_KILL: begin
          if (step_r == apos_r) begin
            ring.wb.live = 1'b0;
            ring.wb.rlen = '0;
            ring.wb.req  = '0;
          end
        end
        ffba_pkg::AM_INSERT: begin
          if (step_r == apos_r) begin
            ring.wb = aval_r;
          end else if (step_r > apos_r) begin
            ring.wb = hold_r;
          end
        end
        default: ring.wb = head;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ffba_pkg::S_IDLE;
      count_r     <= '0;
      skip_r      <= ffba_pkg::SKIP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) skip_r <= cfg_wdata;
      if (state_r == ffba_pkg::S_DECIDE) begin
        if (dec_trim) begin
          count_r <= lastlive_r;
        end else if (dec_inc) begin
          count_r <= count_r + CNT_W'(1);
        end
      end
      if ((state_r == ffba_pkg::S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // transaction latch, scan statistics, apply setup and output register
  always_ff @(posedge clk) begin
    if (ring.shift) begin
      step_r <= last_step ? '0 : step_r + IDX_W'(1);
    end
    if (state_r == ffba_pkg::S_APPLY) hold_r <= head;

    if ((state_r == ffba_pkg::S_IDLE) && in_acc) begin
      kind_r       <= ffba_pkg::kind_t'(in_ch.kind);
      null_r       <= in_ch.address_null;
      size_r       <= in_ch.size;
      addr_r       <= in_ch.address;
      need_r       <= {need_raw[ffba_pkg::NEED_W-1:2], 2'b00};
      free_phase_r <= 1'b0;
      move_r       <= 1'b0;
      step_r       <= '0;
      res_st_r     <= ffba_pkg::ST_OK;
      res_addr_r   <= '0;
      res_copy_r   <= 1'b0;
      res_csrc_r   <= '0;
      res_clen_r   <= '0;
      res_live_r   <= '0;
    end
    if (stat_clr) free_phase_r <= 1'b1;

    if (((state_r == ffba_pkg::S_IDLE) && in_acc) || stat_clr) begin
      cursor_r   <= '0;
      gfound_r   <= 1'b0;
      reuse_r    <= 1'b0;
      prevlive_r <= 1'b0;
      ffound_r   <= 1'b0;
      lastlive_r <= '0;
      livecnt_r  <= '0;
    end else if (state_r == ffba_pkg::S_SCAN) begin
      prevlive_r <= head.live;
      if (g_hit) begin
        gfound_r <= 1'b1;
        gidx_r   <= step_r;
        reuse_r  <= (step_r != '0) && !prevlive_r;
      end
      if (g_adv) cursor_r <= hend;
      if (f_hit) begin
        ffound_r <= 1'b1;
        fidx_r   <= step_r;
        frlen_r  <= head.rlen;
        freq_r   <= head.req;
      end
      if (ll_upd) lastlive_r <= CNT_W'(step_r) + CNT_W'(1);
      if (lc_upd) livecnt_r <= livecnt_r + CNT_W'(1);
    end

    if (state_r == ffba_pkg::S_DECIDE) begin
      am_r   <= dec_mode;
      apos_r <= dec_pos;
      aval_r <= dec_val;
      move_r <= dec_move;
      if (!free_phase_r) begin
        res_st_r   <= dec_st;
        res_addr_r <= dec_addr;
        if (dec_move) begin
          res_copy_r <= 1'b1;
          res_csrc_r <= addr_r;
          res_clen_r <= freq_r;
        end
        if (kind_r == ffba_pkg::K_COUNT) res_live_r <= livecnt_r;
      end
    end

    if ((state_r == ffba_pkg::S_DONE) && out_free) begin
      out_st_r   <= res_st_r;
      out_addr_r <= res_addr_r;
      out_copy_r <= res_copy_r;
      out_csrc_r <= res_csrc_r;
      out_clen_r <= res_clen_r;
      out_live_r <= ffba_pkg::LIVE_W'(res_live_r);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_st_r;
  assign out_ch.block_address = out_addr_r;
  assign out_ch.copy_needed   = out_copy_r;
  assign out_ch.copy_source   = out_csrc_r;
  assign out_ch.copy_length   = out_clen_r;
  assign out_ch.live_count    = out_live_r;

endmodule

>>> sv/first_fit_block_allocator_core.sv
// First-fit block allocator over a 1 MiB arena. The block table, kept in
// address order, lives in a ring of TABLE_ENTRIES cells that rotates one
// entry per cycle past a sequencer during scan and update passes; every
// pass goes once around the whole table. One transaction is worked at a
// time: a free of a null pointer needs no pass, count one scan pass,
// allocate, free and an in-place reallocate one scan pass and, when they
// change the table, one update pass that may insert by shifting the ring;
// a reallocate that moves the block adds a second scan and update pass, in
// which the old block is freed. A new input transaction is taken as soon as
// the sequencer is idle, even while the previous result still waits in the
// output register. leak_skip_entries is written through cfg_we/cfg_wdata
// and must only change while the block is idle.
module first_fit_block_allocator_core #(
  parameter int TABLE_ENTRIES = ffba_pkg::TABLE_ENTRIES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  ffba_in_if.sink                       in_ch,
  ffba_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [ffba_pkg::SKIP_W-1:0]   cfg_wdata
);

  // cell k hands its entry to cell k-1 on each shift; cell 0 is the head
  // the sequencer reads, and the entry it writes back enters at the tail
  ffba_pkg::entry_t    cell_q [TABLE_ENTRIES];
  ffba_pkg::ring_ctl_t ring;
  ffba_pkg::entry_t    head;

  assign head = cell_q[0];

  for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
    if (k == TABLE_ENTRIES - 1) begin : g_tail
      ffba_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .shift (ring.shift),
        .d     (ring.wb),
        .q     (cell_q[k])
      );
    end else begin : g_body
      ffba_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .shift (ring.shift),
        .d     (cell_q[k+1]),
        .q     (cell_q[k])
      );
    end
  end

  // sequencer: scan statistics, first-fit decision, update pass, result register
  ffba_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .head      (head),
    .ring      (ring)
  );

  // the ring never moves while a new transaction is taken
  a_idle_accept : assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |-> !ring.shift)
    else $error("transaction accepted while the table ring rotates");

  // one transaction in flight: ready drops right after an accept
  a_one_in_flight : assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("second transaction accepted while one is in flight");

  // a result is published only once the table passes are finished
  a_result_after_pass : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> !ring.shift)
    else $error("result published during a table pass");

  // table contents hold while the ring stands still
  a_table_holds : assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && !ring.shift |=> $stable(head))
    else $error("head entry changed without a shift");

endmodule

>>> dv/first_fit_block_allocator_core_test.sv
`timescale 1ns / 1ps

module first_fit_block_allocator_core_test;

  // one expected result transaction
  typedef struct {
    logic [ffba_pkg::ADDR_W-1:0] block_address;
    ffba_pkg::status_t           status;
    logic                        copy_needed;
    logic [ffba_pkg::ADDR_W-1:0] copy_source;
    logic [ffba_pkg::LEN_W-1:0]  copy_length;
    logic [ffba_pkg::LIVE_W-1:0] live_count;
  } alloc_result_t;

  localparam int IDLE_LIMIT = 40000;  // cycles with no transaction on either side

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [ffba_pkg::SKIP_W-1:0] cfg_wdata;

  ffba_in_if  in_ch ();
  ffba_out_if out_ch ();

  first_fit_block_allocator_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // 20 ns period
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------------
  // allocator shadow: block table in address order, same widths as the block
  // ---------------------------------------------------------------------------
  logic [ffba_pkg::ADDR_W-1:0] tbl_base [ffba_pkg::TABLE_ENTRIES];
  logic [ffba_pkg::LEN_W-1:0]  tbl_rlen [ffba_pkg::TABLE_ENTRIES];
  logic [ffba_pkg::LEN_W-1:0]  tbl_req  [ffba_pkg::TABLE_ENTRIES];
  logic                        tbl_live [ffba_pkg::TABLE_ENTRIES];
  int                          tbl_count;
  logic [ffba_pkg::SKIP_W-1:0] leak_skip;

  alloc_result_t pending_results[$];
  int  mismatch_count;
  bit  timed_out;

  // sender and receiver knobs, changed by the tests
  int  burst_left;
  int  max_gap;
  int  stall_pct;
  int  hold_off_cycles;

  function automatic void shadow_reset();
    for (int i = 0; i < ffba_pkg::TABLE_ENTRIES; i++) begin
      tbl_base[i] = '0;
      tbl_rlen[i] = '0;
      tbl_req[i]  = '0;
      tbl_live[i] = 1'b0;
    end
    tbl_count = 0;
    leak_skip = ffba_pkg::SKIP_RESET;
  endfunction

  function automatic void set_entry(int idx, longint base, longint rlen,
                                    logic [ffba_pkg::LEN_W-1:0] req);
    tbl_base[idx] = base[ffba_pkg::ADDR_W-1:0];
    tbl_rlen[idx] = rlen[ffba_pkg::LEN_W-1:0];
    tbl_req[idx]  = req;
    tbl_live[idx] = 1'b1;
  endfunction

  // first-fit search: reuse a dead slot before the gap, else shift and insert,
  // else append after the last bounding block
  function automatic ffba_pkg::status_t first_fit_alloc(
      logic [ffba_pkg::LEN_W-1:0] size, output logic [ffba_pkg::ADDR_W-1:0] addr);
    longint need;
    longint cursor;
    need   = (longint'(size) + 3) / 4 * 4;
    cursor = 0;
    addr   = '0;
    for (int i = 0; i < tbl_count; i++) begin
      if (!tbl_live[i] || tbl_rlen[i] == 0) continue;
      if (longint'(tbl_base[i]) < cursor || longint'(tbl_base[i]) - cursor >= need) begin
        if (i > 0 && !tbl_live[i-1]) begin
          set_entry(i - 1, cursor, need, size);
        end else begin
          if (tbl_count >= ffba_pkg::TABLE_ENTRIES) return ffba_pkg::ST_TABLE;
          for (int j = tbl_count; j > i; j--) begin
            tbl_base[j] = tbl_base[j-1];
            tbl_rlen[j] = tbl_rlen[j-1];
            tbl_req[j]  = tbl_req[j-1];
            tbl_live[j] = tbl_live[j-1];
          end
          tbl_count++;
          set_entry(i, cursor, need, size);
        end
        addr = cursor[ffba_pkg::ADDR_W-1:0];
        return ffba_pkg::ST_OK;
      end
      cursor = longint'(tbl_base[i]) + longint'(tbl_rlen[i]);
    end
    if (cursor >= ffba_pkg::ARENA_BYTES || cursor + need > ffba_pkg::ARENA_BYTES)
      return ffba_pkg::ST_ARENA;
    if (tbl_count >= ffba_pkg::TABLE_ENTRIES) return ffba_pkg::ST_TABLE;
    set_entry(tbl_count, cursor, need, size);
    tbl_count++;
    addr = cursor[ffba_pkg::ADDR_W-1:0];
    return ffba_pkg::ST_OK;
  endfunction

  function automatic void trim_dead_tail();
    while (tbl_count > 0 && !tbl_live[tbl_count-1]) begin
      tbl_rlen[tbl_count-1] = '0;
      tbl_req[tbl_count-1]  = '0;
      tbl_count--;
    end
  endfunction

  function automatic int find_block(logic [ffba_pkg::ADDR_W-1:0] addr);
    for (int i = 0; i < tbl_count; i++)
      if (tbl_live[i] && tbl_base[i] == addr) return i;
    return -1;
  endfunction

  function automatic ffba_pkg::status_t release_block(logic [ffba_pkg::ADDR_W-1:0] addr);
    int idx;
    ffba_pkg::status_t st;
    idx = find_block(addr);
    st  = ffba_pkg::ST_UNKNOWN;
    if (idx >= 0) begin
      tbl_live[idx] = 1'b0;
      tbl_rlen[idx] = '0;
      tbl_req[idx]  = '0;
      st = ffba_pkg::ST_OK;
    end
    trim_dead_tail();
    return st;
  endfunction

  // works out the result of one accepted transaction and updates the shadow
  function automatic alloc_result_t predict_alloc_op(ffba_pkg::kind_t kind,
                                                     logic [ffba_pkg::LEN_W-1:0] size,
                                                     logic [ffba_pkg::ADDR_W-1:0] addr,
                                                     logic is_null);
    alloc_result_t r;
    int idx;
    longint need;
    logic [ffba_pkg::ADDR_W-1:0] old_base;
    logic [ffba_pkg::LEN_W-1:0]  old_req;
    r = '{default: '0, status: ffba_pkg::ST_OK};
    case (kind)
      ffba_pkg::K_ALLOC: begin
        r.status = first_fit_alloc(size, r.block_address);
      end
      ffba_pkg::K_FREE: begin
        if (!is_null) r.status = release_block(addr);
      end
      ffba_pkg::K_REALLOC: begin
        if (is_null) begin
          r.status = first_fit_alloc(size, r.block_address);
        end else begin
          idx = find_block(addr);
          if (idx < 0) begin
            r.status = ffba_pkg::ST_UNKNOWN;
          end else begin
            need = (longint'(size) + 3) / 4 * 4;
            if (longint'(tbl_rlen[idx]) >= need) begin
              // shrink in place
              tbl_rlen[idx] = need[ffba_pkg::LEN_W-1:0];
              tbl_req[idx]  = size;
              r.block_address = tbl_base[idx];
            end else begin
              old_base = tbl_base[idx];
              old_req  = tbl_req[idx];
              r.status = first_fit_alloc(size, r.block_address);
              if (r.status == ffba_pkg::ST_OK) begin
                r.copy_needed = 1'b1;
                r.copy_source = old_base;
                r.copy_length = old_req;
                void'(release_block(old_base));
              end
            end
          end
        end
      end
      default: begin
        trim_dead_tail();
        for (int i = leak_skip; i < tbl_count; i++)
          if (tbl_live[i]) r.live_count++;
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus driving, all at the falling edge
  // ---------------------------------------------------------------------------
  task automatic send_op(ffba_pkg::kind_t kind, logic [ffba_pkg::LEN_W-1:0] size,
                         logic [ffba_pkg::ADDR_W-1:0] addr, logic is_null);
    if (burst_left <= 0) begin
      in_ch.valid = 1'b0;
      if (max_gap > 0) repeat ($urandom_range(0, max_gap)) @(negedge clk);
      burst_left = $urandom_range(1, 10);
    end
    in_ch.valid        = 1'b1;
    in_ch.kind         = kind;
    in_ch.size         = size;
    in_ch.address      = addr;
    in_ch.address_null = is_null;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.push_back(predict_alloc_op(kind, size, addr, is_null));
    burst_left--;
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic wait_all_results();
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // skip register is only written with the block idle
  task automatic write_leak_skip(logic [ffba_pkg::SKIP_W-1:0] value);
    wait_all_results();
    repeat (8) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
    leak_skip = value;
  endtask

  // base of a random live block, or a random offset when none is live
  function automatic logic [ffba_pkg::ADDR_W-1:0] pick_live_base();
    int hits[$];
    for (int i = 0; i < tbl_count; i++)
      if (tbl_live[i]) hits.push_back(i);
    if (hits.size() == 0) return ffba_pkg::ADDR_W'($urandom);
    return tbl_base[hits[$urandom_range(0, hits.size() - 1)]];
  endfunction

  function automatic logic [ffba_pkg::LEN_W-1:0] pick_size();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return ffba_pkg::LEN_W'($urandom_range(0, 256));
    if (roll < 92) return ffba_pkg::LEN_W'($urandom_range(257, 8192));
    if (roll < 98) return ffba_pkg::LEN_W'($urandom_range(8193, 262144));
    return ffba_pkg::LEN_W'($urandom_range(0, ffba_pkg::ARENA_BYTES));
  endfunction

  // ---------------------------------------------------------------------------
  // result side: stall pattern at the falling edge, check at the rising edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready = 1'b0;
    end else if (hold_off_cycles > 0) begin
      // long receiver hold-off, counted here
      out_ch.ready = 1'b0;
      hold_off_cycles--;
    end else begin
      out_ch.ready = ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    alloc_result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result transaction: addr=%h status=%0d",
                   out_ch.block_address, out_ch.status);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_ch.block_address !== exp_r.block_address ||
            out_ch.status        !== exp_r.status        ||
            out_ch.copy_needed   !== exp_r.copy_needed   ||
            out_ch.copy_source   !== exp_r.copy_source   ||
            out_ch.copy_length   !== exp_r.copy_length   ||
            out_ch.live_count    !== exp_r.live_count) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"mismatch: exp addr=%h st=%0d cp=%b src=%h len=%0d live=%0d",
                      " | got addr=%h st=%0d cp=%b src=%h len=%0d live=%0d"},
                     exp_r.block_address, exp_r.status, exp_r.copy_needed,
                     exp_r.copy_source, exp_r.copy_length, exp_r.live_count,
                     out_ch.block_address, out_ch.status, out_ch.copy_needed,
                     out_ch.copy_source, out_ch.copy_length, out_ch.live_count);
        end
      end
    end
  end

  // watchdog: cycles with no transaction on either channel
  int idle_cycles;
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_basic_ops();
    logic [ffba_pkg::ADDR_W-1:0] a;
    send_op(ffba_pkg::K_COUNT, '0, '0, 1'b0);                // empty table
    send_op(ffba_pkg::K_ALLOC, 21'd0, '0, 1'b0);             // zero length, bounds no gap
    send_op(ffba_pkg::K_ALLOC, 21'd1, '0, 1'b0);             // same base as the zero block
    send_op(ffba_pkg::K_ALLOC, 21'd5, '0, 1'b0);
    send_op(ffba_pkg::K_ALLOC, 21'd100, '0, 1'b0);
    send_op(ffba_pkg::K_FREE, '0, 20'd0, 1'b0);              // duplicate base, first wins
    send_op(ffba_pkg::K_FREE, '0, 20'hFFFFF, 1'b1);          // free of null
    send_op(ffba_pkg::K_FREE, '0, 20'hFFFFF, 1'b0);          // unknown address
    send_op(ffba_pkg::K_FREE, '0, 20'd4, 1'b0);              // hole in the middle
    send_op(ffba_pkg::K_ALLOC, 21'd3, '0, 1'b0);             // reuses dead slot before gap
    send_op(ffba_pkg::K_ALLOC, 21'd64, '0, 1'b0);            // no gap, appended
    send_op(ffba_pkg::K_REALLOC, 21'd7, 20'hABCDE, 1'b1);    // realloc of null
    send_op(ffba_pkg::K_REALLOC, 21'd7, 20'h55555, 1'b0);    // realloc of unknown
    a = pick_live_base();
    send_op(ffba_pkg::K_REALLOC, 21'd0, a, 1'b0);            // shrink in place
    a = pick_live_base();
    send_op(ffba_pkg::K_REALLOC, 21'd3000, a, 1'b0);         // grow, block moves
    a = pick_live_base();
    send_op(ffba_pkg::K_REALLOC, 21'd1048576, a, 1'b0);      // grow fails, old block stays
    send_op(ffba_pkg::K_ALLOC, 21'd1048576, '0, 1'b0);       // arena exhausted
    send_op(ffba_pkg::K_ALLOC, 21'h1FFFFF, '0, 1'b0);        // all size bits set
    send_op(ffba_pkg::K_COUNT, '0, '0, 1'b0);
  endtask

  task automatic test_leak_skip();
    write_leak_skip(5'd0);
    send_op(ffba_pkg::K_COUNT, '0, '0, 1'b0);
    write_leak_skip(5'd16);
    send_op(ffba_pkg::K_COUNT, '0, '0, 1'b0);
    write_leak_skip(5'd31);
    send_op(ffba_pkg::K_COUNT, '0, '0, 1'b0);
    write_leak_skip(5'd1);
    send_op(ffba_pkg::K_COUNT, '0, '0, 1'b0);
  endtask

  // mostly well-formed traffic on live blocks, some noise
  task automatic test_random_mix(int n_ops);
    int roll;
    for (int k = 0; k < n_ops; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 40)
        send_op(ffba_pkg::K_ALLOC, pick_size(), ffba_pkg::ADDR_W'($urandom), 1'b0);
      else if (roll < 62)
        send_op(ffba_pkg::K_FREE, ffba_pkg::LEN_W'($urandom), pick_live_base(), 1'b0);
      else if (roll < 82)
        send_op(ffba_pkg::K_REALLOC, pick_size(), pick_live_base(), 1'b0);
      else if (roll < 88)
        send_op(ffba_pkg::K_COUNT, ffba_pkg::LEN_W'($urandom),
                ffba_pkg::ADDR_W'($urandom), 1'($urandom));
      else if (roll < 94)
        send_op(ffba_pkg::kind_t'($urandom_range(ffba_pkg::K_FREE, ffba_pkg::K_REALLOC)),
                pick_size(), ffba_pkg::ADDR_W'($urandom), 1'b0);
      else
        send_op(ffba_pkg::kind_t'($urandom_range(ffba_pkg::K_ALLOC, ffba_pkg::K_REALLOC)),
                pick_size(), ffba_pkg::ADDR_W'($urandom), 1'b1);
    end
  endtask

  // receiver holds off while the sender keeps offering, then a full drain
  task automatic test_backpressure();
    hold_off_cycles = 12000;
    test_random_mix(6);
    wait_all_results();
    test_random_mix(4);
  endtask

  task automatic test_arena_fill();
    for (int k = 0; k < 6; k++)
      send_op(ffba_pkg::K_ALLOC, ffba_pkg::LEN_W'($urandom_range(200000, 400000)),
              '0, 1'b0);
    send_op(ffba_pkg::K_COUNT, '0, '0, 1'b0);
    for (int k = 0; k < 6; k++)
      send_op(ffba_pkg::K_FREE, '0, pick_live_base(), 1'b0);
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.kind         = ffba_pkg::K_ALLOC;
    in_ch.size         = '0;
    in_ch.address      = '0;
    in_ch.address_null = 1'b0;
    out_ch.ready       = 1'b0;
    mismatch_count     = 0;
    burst_left         = 0;
    max_gap            = 0;
    stall_pct          = 0;
    hold_off_cycles    = 0;
    shadow_reset();
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_basic_ops();
    test_leak_skip();

    // phases with different idling, skip changed in between
    max_gap = 4;  stall_pct = 30;
    test_random_mix(70);
    write_leak_skip(5'($urandom_range(0, 16)));
    max_gap = 0;  stall_pct = 0;
    test_random_mix(50);
    test_arena_fill();
    write_leak_skip(5'd16);
    max_gap = 8;  stall_pct = 60;
    test_backpressure();
    test_random_mix(60);
    write_leak_skip(5'd0);
    max_gap = 2;  stall_pct = 15;
    test_random_mix(80);
    send_op(ffba_pkg::K_COUNT, '0, '0, 1'b0);

    wait_all_results();
    repeat (50) @(negedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/ffba_pkg.sv
sv/ffba_in_if.sv
sv/ffba_out_if.sv
sv/ffba_cell.sv
sv/ffba_ctrl.sv
sv/first_fit_block_allocator_core.sv
dv/first_fit_block_allocator_core_test.sv
